/* hdl/ttm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ttm_pkg;

  // Table size and result cap.
  localparam int NUM_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Operation codes carried by the kind field.
  typedef enum logic [2:0] {
    K_TICK      = 3'd0,
    K_SET       = 3'd1,
    K_CLEAR     = 3'd2,
    K_PAUSE     = 3'd3,
    K_UNPAUSE   = 3'd4,
    K_ADD       = 3'd5,
    K_QUERY     = 3'd6,
    K_CLR_OWNER = 3'd7
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXPIRED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Contents of one timer slot.
  typedef struct packed {
    logic               valid;
    logic               paused;
    logic               looping;
    logic [15:0]        handle;
    logic [7:0]         owner;
    logic [30:0]        duration;
    logic signed [31:0] remaining;
  } slot_t;

endpackage
`default_nettype wire

/* hdl/ttm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Command channel.
interface ttm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [15:0]        handle;
  logic [7:0]         owner;
  logic [30:0]        duration;
  logic               looping;
  logic signed [31:0] amount;
  modport source (output valid, kind, handle, owner, duration, looping, amount,
                  input ready);
  modport sink   (input valid, kind, handle, owner, duration, looping, amount,
                  output ready);
endinterface

// Result channel.
interface ttm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        out_handle;
  logic [7:0]         out_owner;
  logic signed [31:0] remaining;
  logic               last;
  modport source (output valid, status, out_handle, out_owner, remaining, last,
                  input ready);
  modport sink   (input valid, status, out_handle, out_owner, remaining, last,
                  output ready);
endinterface
`default_nettype wire

/* hdl/ttm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module ttm_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire ttm_pkg::slot_t slot_in,
  output ttm_pkg::slot_t     slot_out
);
  import ttm_pkg::*;

  slot_t slot_r;

  // One timer slot; on a shift it takes the contents of its neighbour.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid  <= 1'b0;
      slot_r.paused <= 1'b0;
    end else if (shift_en) begin
      slot_r <= slot_in;
    end
  end

  assign slot_out = slot_r;

endmodule
`default_nettype wire

/* hdl/timer_table_manager_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Timer table manager. The timer slots sit in a ring of cells. The ring
// rotates by one slot each cycle past a single processing head while the
// scan is not stalled, so every command visits the slots in ascending
// order. A command is accepted in the idle cycle, then scans every slot
// and delivers its final result from the finish state. The scan stalls
// while an expiry is held and the result register cannot take it. The
// finish state waits while the result register is still occupied. A tick
// delivers one expiry transaction per expired timer, and none if nothing
// expires. Every other command delivers exactly one transaction. Commands
// are taken one at a time.
module timer_table_manager_top (
  input wire logic  clk,
  input wire logic  rst_n,
  ttm_in_if.sink    in_chan,
  ttm_out_if.source out_chan
);
  import ttm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t              state_r;
  kind_t               kind_r;
  logic [15:0]         handle_r;
  logic [7:0]          owner_r;
  logic [30:0]         dur_r;
  logic                loop_r;
  logic signed [31:0]  amt_r;
  logic [CNT_W-1:0]    step_r;
  logic [RES_W-1:0]    nres_r;
  logic                found_r;
  logic signed [31:0]  qrem_r;
  logic [15:0]         next_handle_r;
  logic                pend_valid_r;
  logic [15:0]         pend_handle_r;
  logic [7:0]          pend_owner_r;

  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [15:0]         out_handle_r;
  logic [7:0]          out_owner_r;
  logic signed [31:0]  out_rem_r;
  logic                out_last_r;

  slot_t chain [NUM_TIMERS];
  slot_t head_new;
  logic  shift_en;

  // Saturating 32-bit add or subtract.
  function automatic logic signed [31:0] sat_op(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic sub);
    logic signed [32:0] s;
    begin
      s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
      if (s[32] != s[31]) begin
        sat_op = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        sat_op = s[31:0];
      end
    end
  endfunction

  // Ring of cells: the head slot re-enters at the far end after processing.
  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    slot_t cell_in;
    if (k == NUM_TIMERS - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_mid
      assign cell_in = chain[k+1];
    end
    ttm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .slot_in  (cell_in),
      .slot_out (chain[k])
    );
  end

  // Processing of the slot at the head of the ring.
  slot_t              h;
  logic               expired;
  logic               hit;
  logic signed [31:0] tick_rem;
  assign h = chain[0];
  assign tick_rem = sat_op(h.remaining, amt_r, 1'b1);

  always_comb begin
    head_new = h;
    expired  = 1'b0;
    hit      = 1'b0;
    case (kind_r)
      K_TICK: begin
        if (h.valid && !h.paused) begin
          head_new.remaining = tick_rem;
          if (tick_rem[31] || tick_rem == 32'sd0) begin
            expired = 1'b1;
            if (h.looping) begin
              head_new.remaining = $signed({1'b0, h.duration});
            end else begin
              head_new.valid = 1'b0;
            end
          end
        end
      end
      K_SET: begin
        if (!found_r && !h.valid) begin
          hit = 1'b1;
          head_new.valid     = 1'b1;
          head_new.paused    = 1'b0;
          head_new.looping   = loop_r;
          head_new.handle    = next_handle_r;
          head_new.owner     = owner_r;
          head_new.duration  = dur_r;
          head_new.remaining = $signed({1'b0, dur_r});
        end
      end
      K_CLR_OWNER: begin
        if (h.valid && h.owner == owner_r) begin
          head_new.valid = 1'b0;
        end
      end
      default: begin
        if (!found_r && h.valid && h.handle == handle_r) begin
          hit = 1'b1;
          case (kind_r)
            K_CLEAR:   head_new.valid = 1'b0;
            K_PAUSE:   head_new.paused = 1'b1;
            K_UNPAUSE: head_new.paused = 1'b0;
            K_ADD:     head_new.remaining = sat_op(h.remaining, amt_r, 1'b0);
            default:   head_new = h;
          endcase
        end
      end
    endcase
  end

  // Flow control between the scan and the result register.
  logic out_free, report, need_push, out_load;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign report    = expired && (nres_r < RES_W'(MAX_RESULTS));
  assign need_push = report && pend_valid_r;
  assign shift_en  = (state_r == S_SCAN) && (!need_push || out_free);
  // The result register is loaded by a pushed expiry or by the final result.
  assign out_load  = ((state_r == S_SCAN) && shift_en && need_push) ||
                     ((state_r == S_FINISH) && out_free &&
                      ((kind_r != K_TICK) || pend_valid_r));

  // Sequencer, held expiry and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      next_handle_r <= 16'd0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      found_r       <= 1'b0;
      step_r        <= '0;
      nres_r        <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            kind_r   <= kind_t'(in_chan.kind);
            handle_r <= in_chan.handle;
            owner_r  <= in_chan.owner;
            dur_r    <= in_chan.duration;
            loop_r   <= in_chan.looping;
            amt_r    <= in_chan.amount;
            step_r   <= '0;
            nres_r   <= '0;
            found_r  <= 1'b0;
            qrem_r   <= 32'sd0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (shift_en) begin
            if (hit) begin
              found_r <= 1'b1;
              qrem_r  <= head_new.remaining;
            end
            if (need_push) begin
              out_status_r <= ST_EXPIRED;
              out_handle_r <= pend_handle_r;
              out_owner_r  <= pend_owner_r;
              out_rem_r    <= 32'sd0;
              out_last_r   <= 1'b0;
            end
            if (report) begin
              pend_valid_r  <= 1'b1;
              pend_handle_r <= h.handle;
              pend_owner_r  <= h.owner;
              nres_r        <= nres_r + RES_W'(1);
            end
            if (step_r == CNT_W'(NUM_TIMERS - 1)) begin
              state_r <= S_FINISH;
            end
            step_r <= step_r + CNT_W'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_r      <= S_IDLE;
            pend_valid_r <= 1'b0;
            out_last_r   <= 1'b1;
            case (kind_r)
              K_TICK: begin
                out_status_r <= ST_EXPIRED;
                out_handle_r <= pend_handle_r;
                out_owner_r  <= pend_owner_r;
                out_rem_r    <= 32'sd0;
              end
              K_SET: begin
                out_owner_r <= 8'd0;
                out_rem_r   <= 32'sd0;
                if (found_r) begin
                  out_status_r  <= ST_DONE;
                  out_handle_r  <= next_handle_r;
                  next_handle_r <= next_handle_r + 16'd1;
                end else begin
                  out_status_r <= ST_FULL;
                  out_handle_r <= 16'd0;
                end
              end
              K_CLR_OWNER: begin
                out_status_r <= ST_DONE;
                out_handle_r <= 16'd0;
                out_owner_r  <= 8'd0;
                out_rem_r    <= 32'sd0;
              end
              default: begin
                out_handle_r <= 16'd0;
                out_owner_r  <= 8'd0;
                if (!found_r) begin
                  out_status_r <= ST_NOT_FOUND;
                  out_rem_r    <= (kind_r == K_QUERY) ? -32'sd1 : 32'sd0;
                end else begin
                  out_status_r <= ST_DONE;
                  out_rem_r    <= (kind_r == K_QUERY) ? qrem_r : 32'sd0;
                end
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.out_handle = out_handle_r;
  assign out_chan.out_owner  = out_owner_r;
  assign out_chan.remaining  = out_rem_r;
  assign out_chan.last       = out_last_r;

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ttm_pkg::*;

  // One command and one result as the predictor sees them.
  typedef struct {
    kind_t              kind;
    logic [15:0]        handle;
    logic [7:0]         owner;
    logic [30:0]        duration;
    logic               looping;
    logic signed [31:0] amount;
  } cmd_t;

  typedef struct {
    status_t            status;
    logic [15:0]        out_handle;
    logic [7:0]         out_owner;
    logic signed [31:0] remaining;
    logic               last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ttm_in_if  in_chan ();
  ttm_out_if out_chan ();

  timer_table_manager_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #10 clk = ~clk;

  // Model copy of the timer table.
  slot_t       tbl [NUM_TIMERS];
  logic [15:0] handle_ctr;
  logic [15:0] handle_guess = 0;

  cmd_t cmd_q [$];
  res_t expiry_q [$];
  int   errors = 0;
  bit   stim_done = 0;
  bit   hold_sender = 0;

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [32:0] b);
    logic signed [33:0] s;
    s = $signed({{2{a[31]}}, a}) + $signed({b[32], b});
    if (s > 34'sd2147483647) return 32'sh7fffffff;
    if (s < -34'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic res_t mk_res(status_t st, logic [15:0] h, logic [7:0] o,
                                  logic signed [31:0] r, logic l);
    res_t x;
    x.status = st; x.out_handle = h; x.out_owner = o; x.remaining = r; x.last = l;
    return x;
  endfunction

  // Apply one command to the model table and queue the results it causes.
  task automatic apply_timer_cmd(cmd_t c);
    int   n, s;
    n = 0;
    s = -1;
    case (c.kind)
      K_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tbl[i].valid && !tbl[i].paused) begin
            tbl[i].remaining = sat_sum(tbl[i].remaining, -$signed({c.amount[31], c.amount}));
            if (tbl[i].remaining <= 0) begin
              if (n < MAX_RESULTS) begin
                expiry_q = {expiry_q,
                            mk_res(ST_EXPIRED, tbl[i].handle, tbl[i].owner, 0, 1'b0)};
                n++;
              end
              if (tbl[i].looping) tbl[i].remaining = {1'b0, tbl[i].duration};
              else tbl[i].valid = 1'b0;
            end
          end
        end
        if (n > 0) begin
          expiry_q[$].last = 1'b1;
        end
      end
      K_SET: begin
        for (int i = NUM_TIMERS - 1; i >= 0; i--) if (!tbl[i].valid) s = i;
        if (s < 0) begin
          expiry_q = {expiry_q, mk_res(ST_FULL, 0, 0, 0, 1'b1)};
        end else begin
          tbl[s].valid = 1'b1;
          tbl[s].paused = 1'b0;
          tbl[s].looping = c.looping;
          tbl[s].handle = handle_ctr;
          tbl[s].owner = c.owner;
          tbl[s].duration = c.duration;
          tbl[s].remaining = {1'b0, c.duration};
          expiry_q = {expiry_q, mk_res(ST_DONE, handle_ctr, 0, 0, 1'b1)};
          handle_ctr++;
        end
      end
      K_CLR_OWNER: begin
        for (int i = 0; i < NUM_TIMERS; i++)
          if (tbl[i].valid && tbl[i].owner == c.owner) tbl[i].valid = 1'b0;
        expiry_q = {expiry_q, mk_res(ST_DONE, 0, 0, 0, 1'b1)};
      end
      default: begin
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
          if (tbl[i].valid && tbl[i].handle == c.handle) s = i;
        if (s < 0) begin
          expiry_q = {expiry_q, mk_res(ST_NOT_FOUND, 0, 0,
                                       (c.kind == K_QUERY) ? -32'sd1 : 32'sd0, 1'b1)};
        end else begin
          case (c.kind)
            K_CLEAR:   tbl[s].valid = 1'b0;
            K_PAUSE:   tbl[s].paused = 1'b1;
            K_UNPAUSE: tbl[s].paused = 1'b0;
            K_ADD:     tbl[s].remaining = sat_sum(tbl[s].remaining,
                                                  $signed({c.amount[31], c.amount}));
            default: ;
          endcase
          expiry_q = {expiry_q, mk_res(ST_DONE, 0, 0,
                                       (c.kind == K_QUERY) ? tbl[s].remaining : 32'sd0,
                                       1'b1)};
        end
      end
    endcase
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Handles recently issued, so random commands mostly hit live timers.
  function automatic logic [15:0] pick_handle();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7 && handle_guess > 0) return 16'(handle_guess - $urandom_range(1, 20));
    if (p < 8) return handle_guess;
    return 16'($urandom());
  endfunction

  function automatic logic signed [31:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -$signed(32'($urandom_range(0, 500)));
      3: return $urandom();
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  function automatic cmd_t mk_cmd(kind_t k, logic [15:0] h, logic [7:0] o,
                                  logic [30:0] d, logic l, logic signed [31:0] a);
    cmd_t c;
    c.kind = k; c.handle = h; c.owner = o; c.duration = d; c.looping = l; c.amount = a;
    return c;
  endfunction

  // Command source: directed cases first, then a random mix.
  initial begin
    cmd_t c;
    cmd_q = {cmd_q, mk_cmd(K_TICK, 0, 0, 0, 0, 5)};
    cmd_q = {cmd_q, mk_cmd(K_QUERY, 16'hffff, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_CLEAR, 0, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_PAUSE, 0, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_UNPAUSE, 0, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_ADD, 0, 0, 0, 0, 1)};
    for (int i = 0; i < 17; i++)
      cmd_q = {cmd_q, mk_cmd(K_SET, 0, 8'(i % 3 == 0 ? 8'hff : i), (i == 0) ? 31'h7fffffff :
                             (i == 1) ? 31'd0 : 31'(i * 10), 1'(i % 2), 0)};
    cmd_q = {cmd_q, mk_cmd(K_PAUSE, 1, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_ADD, 0, 0, 0, 0, 32'sh7fffffff)};
    cmd_q = {cmd_q, mk_cmd(K_QUERY, 0, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_TICK, 0, 0, 0, 0, 32'sh80000000)};
    cmd_q = {cmd_q, mk_cmd(K_TICK, 0, 0, 0, 0, 32'sh7fffffff)};
    cmd_q = {cmd_q, mk_cmd(K_UNPAUSE, 1, 0, 0, 0, 0)};
    cmd_q = {cmd_q, mk_cmd(K_CLR_OWNER, 0, 8'hff, 0, 0, 0)};
    handle_guess = 17;
    for (int i = 0; i < 448; i++) begin
      if (i == 200) begin
        wait (cmd_q.size() == 0);
        hold_sender = 1;
        wait (expiry_q.size() == 0);
        hold_sender = 0;
      end
      // Random mix of commands, weighted towards set and tick.
      case ($urandom_range(0, 15))
        0, 1, 2, 3: c = mk_cmd(K_SET, 0, 8'($urandom_range(0, 3)), (i % 50 == 7) ?
                      31'($urandom()) : 31'($urandom_range(0, 2000)), 1'($urandom()), 0);
        4, 5, 6: c = mk_cmd(K_TICK, 16'($urandom()), 8'($urandom()), 31'($urandom()),
                            1'($urandom()), pick_amount());
        7: c = mk_cmd(K_CLEAR, pick_handle(), 0, 0, 0, 0);
        8: c = mk_cmd(K_PAUSE, pick_handle(), 0, 0, 0, 0);
        9: c = mk_cmd(K_UNPAUSE, pick_handle(), 0, 0, 0, 0);
        10, 11: c = mk_cmd(K_ADD, pick_handle(), 0, 0, 0, pick_amount());
        12, 13: c = mk_cmd(K_QUERY, pick_handle(), 8'($urandom()), 31'($urandom()),
                           1'($urandom()), $signed($urandom()));
        14: c = mk_cmd(K_CLR_OWNER, 0, ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
                       8'($urandom_range(0, 3)), 0, 0, 0);
        default: c = mk_cmd(K_SET, 0, 8'($urandom()), 31'($urandom_range(0, 100)), 1'b1, 0);
      endcase
      cmd_q = {cmd_q, c};
      wait (cmd_q.size() < 4);
    end
    stim_done = 1;
  end

  // Driver: presents one transaction at a time with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_chan.ready) begin
      // Hold the transaction until it is taken.
    end else begin
      if (in_chan.valid) begin
        apply_timer_cmd(cmd_q.pop_front());
        if (in_chan.kind == K_SET) handle_guess = handle_ctr;
        send_gap = gap_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (cmd_q.size() > 0 && !hold_sender) begin
        in_chan.valid    <= 1'b1;
        in_chan.kind     <= cmd_q[0].kind;
        in_chan.handle   <= cmd_q[0].handle;
        in_chan.owner    <= cmd_q[0].owner;
        in_chan.duration <= cmd_q[0].duration;
        in_chan.looping  <= cmd_q[0].looping;
        in_chan.amount   <= cmd_q[0].amount;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Quiet values on both channels before the first clock edge.
  initial begin
    in_chan.kind = K_TICK;
    in_chan.handle = 0;
    in_chan.owner = 0;
    in_chan.duration = 0;
    in_chan.looping = 0;
    in_chan.amount = 0;
    in_chan.valid = 0;
    out_chan.ready = 0;
  end

  // Monitor: random back-pressure and field checks against the model.
  int stall = 0;
  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expiry_q.size() == 0) begin
          $error("result with no expectation: status %0d handle %0d",
                 out_chan.status, out_chan.out_handle);
          errors++;
        end else begin
          e = expiry_q.pop_front();
          if (out_chan.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_chan.status); errors++;
          end
          if (out_chan.out_handle !== e.out_handle) begin
            $error("out_handle: expected %0d, got %0d", e.out_handle, out_chan.out_handle);
            errors++;
          end
          if (out_chan.out_owner !== e.out_owner) begin
            $error("out_owner: expected %0d, got %0d", e.out_owner, out_chan.out_owner);
            errors++;
          end
          if (out_chan.remaining !== e.remaining) begin
            $error("remaining: expected %0d, got %0d", e.remaining, out_chan.remaining);
            errors++;
          end
          if (out_chan.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_chan.last); errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  // Reset, then wait for the stimulus to drain.
  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) tbl[i] = '0;
    handle_ctr = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && cmd_q.size() == 0 && !in_chan.valid);
    wait (expiry_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expiry_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
